>>> sv/ipv4_subnet_calculator_macros.svh
// Assertion macros shared by the subnet calculator modules.
`ifndef IPV4_SUBNET_CALCULATOR_MACROS_SVH
`define IPV4_SUBNET_CALCULATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define IPV4SC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IPV4SC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define IPV4SC_ASSERT(lbl, clk, rst_n, prop, msg)
`define IPV4SC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> sv/ipv4sc_pkg.sv
package ipv4sc_pkg;

  localparam logic [7:0]  CHAR_DOT    = 8'h2E;
  localparam logic [7:0]  CHAR_ZERO   = 8'h30;
  localparam logic [7:0]  CHAR_NINE   = 8'h39;
  localparam logic [11:0] OCTET_MAX   = 12'd255;
  localparam logic [1:0]  LAST_OCTET  = 2'd3;
  localparam logic [1:0]  MAX_DIGITS  = 2'd3;
  localparam logic [31:0] MASK_FULL   = 32'hFFFF_FFFF;
  localparam logic [31:0] MASK_PAIR   = 32'hFFFF_FFFE;
  localparam logic [5:0]  PREFIX_FULL = 6'd32;
  localparam int          OUT_TDATA_W = 200;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ADDR_ERR = 2'd1,
    ST_MASK_ERR = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] mask;
    logic        mask_err;
    logic [31:0] addr;
    logic        addr_err;
  } done_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] address;
    logic [31:0] mask;
    logic [5:0]  prefix;
    logic [31:0] network;
    logic [31:0] broadcast;
    logic [31:0] low_host;
    logic [31:0] high_host;
  } res_t;

endpackage

>>> sv/ipv4sc_parser.sv
`include "ipv4_subnet_calculator_macros.svh"

module ipv4sc_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        character,
  input  logic              string_select,
  input  logic              last_char,
  input  logic              done_ready,
  output logic              done_valid,
  output ipv4sc_pkg::done_t done
);
  import ipv4sc_pkg::*;

  logic [7:0]  acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] word_r, word_nxt;
  logic        err_r, err_nxt;
  logic [31:0] saved_r;
  logic        saved_err_r;
  logic        done_valid_r;
  done_t       done_r;

  logic [31:0] word_fin;
  logic [11:0] acc_sum;
  logic        is_digit;
  logic        emit;

  function automatic logic [31:0] place_octet(input logic [7:0] a, input logic [1:0] i);
    logic [31:0] w;
    unique case (i)
      2'd0:    w = {a, 24'h0};
      2'd1:    w = {8'h0, a, 16'h0};
      2'd2:    w = {16'h0, a, 8'h0};
      default: w = {24'h0, a};
    endcase
    return w;
  endfunction

  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    word_nxt = word_r;
    err_nxt  = err_r;
    is_digit = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
    acc_sum  = {1'b0, acc_r, 3'b0} + {3'b0, acc_r, 1'b0} + {8'h0, character[3:0]};
    if (!err_r) begin
      if (character == CHAR_DOT) begin
        if (idx_r == LAST_OCTET) begin
          err_nxt = 1'b1;
        end else begin
          word_nxt = word_r | place_octet(acc_r, idx_r);
          acc_nxt  = 8'h0;
          cnt_nxt  = 2'd0;
          idx_nxt  = idx_r + 2'd1;
        end
      end else if (is_digit) begin
        if (cnt_r == MAX_DIGITS || acc_sum > OCTET_MAX) begin
          err_nxt = 1'b1;
        end else begin
          acc_nxt = acc_sum[7:0];
          cnt_nxt = cnt_r + 2'd1;
        end
      end else begin
        err_nxt = 1'b1;
      end
    end
    word_fin = err_nxt ? word_nxt : (word_nxt | place_octet(acc_nxt, idx_nxt));
  end

  assign emit = fire && last_char && string_select;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= 8'h0;
      cnt_r        <= 2'd0;
      idx_r        <= 2'd0;
      word_r       <= 32'h0;
      err_r        <= 1'b0;
      saved_r      <= 32'h0;
      saved_err_r  <= 1'b0;
      done_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        if (last_char) begin
          acc_r  <= 8'h0;
          cnt_r  <= 2'd0;
          idx_r  <= 2'd0;
          word_r <= 32'h0;
          err_r  <= 1'b0;
          if (!string_select) begin
            saved_r     <= word_fin;
            saved_err_r <= err_nxt;
          end
        end else begin
          acc_r  <= acc_nxt;
          cnt_r  <= cnt_nxt;
          idx_r  <= idx_nxt;
          word_r <= word_nxt;
          err_r  <= err_nxt;
        end
      end
      if (done_ready) begin
        done_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      done_r <= '{mask: word_fin, mask_err: err_nxt, addr: saved_r, addr_err: saved_err_r};
    end
  end

  assign done_valid = done_valid_r;
  assign done       = done_r;

  `IPV4SC_ASSERT_IMPL(a_done_from_emit, clk, rst_n, done_valid_r && !$past(done_valid_r), $past(emit), "parser result appeared without a final netmask character")

endmodule

>>> sv/ipv4sc_result.sv
`include "ipv4_subnet_calculator_macros.svh"

module ipv4sc_result (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              done_valid,
  input  ipv4sc_pkg::done_t done,
  output logic              take_ready,
  output logic              res_valid,
  input  logic              res_ready,
  output ipv4sc_pkg::res_t  res
);
  import ipv4sc_pkg::*;

  logic  valid_r;
  res_t  res_r;
  res_t  res_nxt;
  logic [31:0] net;
  logic [31:0] bc;
  logic [31:0] top_ones;
  logic [5:0]  prefix;

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      top_ones[i] = &(done.mask | (MASK_FULL >> (i + 1)));
    end
    prefix = top_ones[31] ? PREFIX_FULL : 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (!top_ones[i] && (i == 0 || top_ones[(i + 31) % 32])) begin
        prefix = prefix | 6'(i);
      end
    end
  end

  always_comb begin
    net     = done.addr & done.mask;
    bc      = done.addr | ~done.mask;
    res_nxt = '0;
    if (done.addr_err) begin
      res_nxt.status = ST_ADDR_ERR;
    end else if (done.mask_err) begin
      res_nxt.status = ST_MASK_ERR;
    end else begin
      res_nxt.status    = ST_OK;
      res_nxt.address   = done.addr;
      res_nxt.mask      = done.mask;
      res_nxt.prefix    = prefix;
      res_nxt.network   = net;
      res_nxt.broadcast = bc;
      if (done.mask == MASK_FULL) begin
        res_nxt.low_host  = net;
        res_nxt.high_host = net;
      end else if (done.mask == MASK_PAIR) begin
        res_nxt.low_host  = net;
        res_nxt.high_host = bc;
      end else begin
        res_nxt.low_host  = net + 32'd1;
        res_nxt.high_host = bc - 32'd1;
      end
    end
  end

  assign take_ready = !valid_r || res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take_ready) begin
      valid_r <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_ready && done_valid) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res       = res_r;

  `IPV4SC_ASSERT_IMPL(a_error_zeroes, clk, rst_n, valid_r && res_r.status != ST_OK, res_r.address == 32'h0 && res_r.mask == 32'h0 && res_r.prefix == 6'd0, "error result carries nonzero fields")
  `IPV4SC_ASSERT_IMPL(a_full_mask, clk, rst_n, valid_r && res_r.status == ST_OK && res_r.mask == MASK_FULL, res_r.prefix == PREFIX_FULL && res_r.low_host == res_r.network && res_r.high_host == res_r.network, "full mask gives wrong prefix or hosts")

endmodule

>>> sv/ipv4_subnet_calculator.sv
// The result passes through the input register, the parser result register and the
// output register after the last netmask transfer; other characters give no result.
// Throughput: one character per cycle except while a final netmask character stalls.
// Reset: rst_n is synchronous and active low; it clears the parser, the saved address
// and all valid flags, so the block comes out of reset ready with no pending result.
`include "ipv4_subnet_calculator_macros.svh"

module ipv4_subnet_calculator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] character
  input  logic [0:0]   in_tuser,   // [0] string_select
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] address_value, [63:32] mask_value, [69:64] prefix_length,
  // [101:70] network_address, [133:102] broadcast_address, [165:134] lowest_host,
  // [197:166] highest_host, [199:198] zero
  output logic [ipv4sc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]   out_tuser   // [1:0] status
);
  import ipv4sc_pkg::*;

  logic       a_valid_r;
  logic [7:0] a_char_r;
  logic       a_sel_r;
  logic       a_last_r;
  logic       a_adv;
  logic       a_emit;
  logic       b_ready;
  logic       take_ready;
  logic       done_valid;
  done_t      done;
  res_t       res;

  assign a_emit    = a_last_r && a_sel_r;
  assign b_ready   = !done_valid || take_ready;
  assign a_adv     = a_valid_r && (!a_emit || b_ready);
  assign in_tready = !a_valid_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_char_r <= in_tdata;
      a_sel_r  <= in_tuser[0];
      a_last_r <= in_tlast;
    end
  end

  ipv4sc_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (a_adv),
    .character     (a_char_r),
    .string_select (a_sel_r),
    .last_char     (a_last_r),
    .done_ready    (b_ready),
    .done_valid    (done_valid),
    .done          (done)
  );

  ipv4sc_result u_result (
    .clk        (clk),
    .rst_n      (rst_n),
    .done_valid (done_valid),
    .done       (done),
    .take_ready (take_ready),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tuser = res.status;
  assign out_tdata = {2'b00, res.high_host, res.low_host, res.broadcast, res.network,
                      res.prefix, res.mask, res.address};

  `IPV4SC_ASSERT_IMPL(a_stall_only_on_emit, clk, rst_n, !in_tready, a_valid_r && a_emit, "input stalled without a pending final netmask character")
  `IPV4SC_ASSERT(a_emit_reaches_parser, clk, rst_n, (a_adv && a_emit) |=> done_valid, "final netmask character produced no parser result")

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import ipv4sc_pkg::*;

  localparam int LIMIT_CYCLES = 400_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TARGET_CHARS = 1700;

  typedef logic [7:0] char_q_t[$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [7:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tready = 1'b0;
  logic in_tready;
  logic out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  // Parser state mirrored from the block, plus the expected subnet results.
  logic [7:0] acc_octet = '0;
  logic [2:0] acc_digits = '0;
  logic [2:0] acc_index = '0;
  logic [31:0] acc_word = '0;
  logic acc_bad = 1'b0;
  logic [31:0] held_address = '0;
  logic held_address_bad = 1'b0;
  res_t pending_subnets[$];

  int mismatches = 0;
  int chars_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int hold_requests = 0;
  int holds_taken = 0;
  int hold_left = 0;
  int phase_left = 0;
  logic [15:0] stall_pattern = '1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ipv4_subnet_calculator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  function automatic void store_octet();
    int unsigned shift;
    shift = 8 * (3 - acc_index[1:0]);
    acc_word |= 32'(acc_octet) << shift;
    acc_octet = '0;
    acc_digits = '0;
  endfunction

  function automatic void restart_parse();
    acc_octet = '0;
    acc_digits = '0;
    acc_index = '0;
    acc_word = '0;
    acc_bad = 1'b0;
  endfunction

  function automatic void parse_character(logic [7:0] c);
    int unsigned t;
    if (acc_bad) return;
    if (c == CHAR_DOT) begin
      if (acc_index >= LAST_OCTET) begin
        acc_bad = 1'b1;
      end else begin
        store_octet();
        acc_index++;
      end
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      t = acc_octet * 10 + (c - CHAR_ZERO);
      if (acc_digits >= MAX_DIGITS || t > OCTET_MAX) begin
        acc_bad = 1'b1;
      end else begin
        acc_octet = t[7:0];
        acc_digits++;
      end
    end else begin
      acc_bad = 1'b1;
    end
  endfunction

  function automatic logic [5:0] count_leading_ones(logic [31:0] m);
    int n;
    n = 0;
    while (n < 32 && m[31]) begin
      n++;
      m = m << 1;
    end
    return 6'(n);
  endfunction

  function automatic void follow_character(logic [7:0] c, logic sel, logic last);
    res_t r;
    logic [31:0] d;
    parse_character(c);
    if (!last) return;
    if (!acc_bad) store_octet();
    if (!sel) begin
      held_address = acc_word;
      held_address_bad = acc_bad;
      restart_parse();
      return;
    end
    r = '0;
    if (held_address_bad) begin
      r.status = ST_ADDR_ERR;
    end else if (acc_bad) begin
      r.status = ST_MASK_ERR;
    end else begin
      r.status = ST_OK;
      r.address = held_address;
      r.mask = acc_word;
      r.prefix = count_leading_ones(acc_word);
      r.network = held_address & acc_word;
      r.broadcast = held_address | ~acc_word;
      d = r.broadcast - r.network;
      if (d == 32'd0) begin
        r.low_host = r.network;
        r.high_host = r.network;
      end else if (d == 32'd1) begin
        r.low_host = r.network;
        r.high_host = r.broadcast;
      end else begin
        r.low_host = r.network + 32'd1;
        r.high_host = r.broadcast - 32'd1;
      end
    end
    pending_subnets.push_back(r);
    restart_parse();
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch in %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_count);
  endtask

  task automatic send_char(logic [7:0] c, logic sel, logic last);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tuser <= sel;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    follow_character(c, sel, last);
    chars_sent++;
  endtask

  task automatic send_text(string s, logic sel);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], sel, i == s.len() - 1);
    end
  endtask

  task automatic send_chars(char_q_t q, logic sel, bit scramble);
    logic s;
    for (int i = 0; i < q.size(); i++) begin
      s = (scramble && i != q.size() - 1) ? 1'($urandom_range(0, 1)) : sel;
      send_char(q[i], s, i == q.size() - 1);
    end
  endtask

  function automatic char_q_t spell(logic [31:0] w);
    char_q_t q;
    string txt;
    string oct;
    int keep;
    logic [7:0] v;
    keep = 4;
    while (keep > 1 && w[8*(4-keep) +: 8] == 8'h00 && $urandom_range(0, 1) == 1) keep--;
    txt = "";
    for (int k = 0; k < keep; k++) begin
      v = w[31-8*k -: 8];
      if (v == 8'h00 && $urandom_range(0, 3) == 0) begin
        oct = "";
      end else begin
        oct = $sformatf("%0d", v);
        while (oct.len() < 3 && $urandom_range(0, 4) == 0) oct = {"0", oct};
      end
      txt = (k == 0) ? oct : {txt, ".", oct};
    end
    if (txt.len() == 0) txt = ".";
    for (int i = 0; i < txt.len(); i++) q.push_back(txt[i]);
    return q;
  endfunction

  function automatic char_q_t damage(char_q_t q);
    int at;
    at = $urandom_range(0, q.size() - 1);
    case ($urandom_range(0, 3))
      0: q[at] = 8'($urandom_range(0, 255));
      1: q.insert(at, CHAR_ZERO + 8'($urandom_range(0, 9)));
      2: q.insert(at, CHAR_NINE);
      default: begin
        q.push_back(CHAR_DOT);
        if ($urandom_range(0, 1) == 1) q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
    endcase
    return q;
  endfunction

  function automatic logic [31:0] pick_address();
    logic [31:0] w;
    w = $urandom;
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 4) == 0) w[8*k +: 8] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
    end
    return w;
  endfunction

  function automatic logic [31:0] pick_mask();
    int r;
    int p;
    r = $urandom_range(0, 19);
    if (r >= 15) return $urandom;
    if (r < 3) begin
      p = (r == 0) ? 0 : 30 + r;
    end else begin
      p = $urandom_range(0, 32);
    end
    return (p == 0) ? 32'h0 : MASK_FULL << (32 - p);
  endfunction

  task automatic test_mask_without_address();
    send_text("255", 1'b1);
  endtask

  task automatic test_host_rules();
    send_text("1..9", 1'b0);
    send_text("0", 1'b1);
    send_text("255.255.255.255", 1'b1);
  endtask

  task automatic test_malformed_strings();
    send_char(8'hFF, 1'b0, 1'b1);
    send_text("0", 1'b1);
    send_text("7", 1'b0);
    send_text("0001", 1'b1);
    send_char(8'h00, 1'b1, 1'b1);
    send_text("1.2.3.4.", 1'b0);
    send_text("256", 1'b1);
  endtask

  task automatic test_interleaved_strings();
    send_char("1", 1'b1, 1'b0);
    send_char("2", 1'b0, 1'b1);
    send_char("3", 1'b0, 1'b0);
    send_char(CHAR_DOT, 1'b1, 1'b1);
  endtask

  // One-character netmask strings each yield a result, so the held-off output backs up fast.
  task automatic test_output_backpressure();
    hold_requests <= hold_requests + 1;
    repeat (80) send_char(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b1, 1'b1);
  endtask

  task automatic test_random_subnets();
    char_q_t q;
    while (chars_sent < TARGET_CHARS) begin
      if ($urandom_range(0, 9) != 0) begin
        q = spell(pick_address());
        if ($urandom_range(0, 7) == 0) q = damage(q);
        send_chars(q, 1'b0, $urandom_range(0, 7) == 0);
      end
      q = spell(pick_mask());
      if ($urandom_range(0, 7) == 0) q = damage(q);
      send_chars(q, 1'b1, $urandom_range(0, 7) == 0);
    end
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_taken != hold_requests) begin
      holds_taken <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (phase_left == 0) begin
      phase_left <= $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0: stall_pattern <= '1;
        default: stall_pattern <= 16'($urandom) | 16'h0001;
      endcase
      out_tready <= 1'b1;
    end else begin
      phase_left <= phase_left - 1;
      stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
      out_tready <= stall_pattern[15];
    end
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_subnets.size() == 0) begin
        flag_mismatch("result with nothing pending", out_tdata[31:0], '0);
      end else begin
        want = pending_subnets.pop_front();
        if (out_tuser !== want.status) begin
          flag_mismatch("status", 32'(out_tuser), 32'(want.status));
        end
        if (out_tdata[31:0] !== want.address) flag_mismatch("address", out_tdata[31:0], want.address);
        if (out_tdata[63:32] !== want.mask) flag_mismatch("mask", out_tdata[63:32], want.mask);
        if (out_tdata[69:64] !== want.prefix) begin
          flag_mismatch("prefix", 32'(out_tdata[69:64]), 32'(want.prefix));
        end
        if (out_tdata[101:70] !== want.network) begin
          flag_mismatch("network", out_tdata[101:70], want.network);
        end
        if (out_tdata[133:102] !== want.broadcast) begin
          flag_mismatch("broadcast", out_tdata[133:102], want.broadcast);
        end
        if (out_tdata[165:134] !== want.low_host) begin
          flag_mismatch("lowest host", out_tdata[165:134], want.low_host);
        end
        if (out_tdata[197:166] !== want.high_host) begin
          flag_mismatch("highest host", out_tdata[197:166], want.high_host);
        end
        if (out_tdata[199:198] !== 2'b00) begin
          flag_mismatch("padding", 32'(out_tdata[199:198]), '0);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("ipv4_subnet_calculator verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_mask_without_address();
    test_host_rules();
    test_malformed_strings();
    test_interleaved_strings();
    test_output_backpressure();
    test_random_subnets();
    in_tvalid <= 1'b0;
    while (pending_subnets.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("ipv4_subnet_calculator verification clean");
    end else begin
      $display("ipv4_subnet_calculator verification failed");
    end
    $finish;
  end

endmodule
